FILE: src/mh2_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MurmurHash2 package
// Constants, datapath command codes and the command/status structs shared by
// the controller and the datapath of the 32-bit MurmurHash2 engine.
// ----------------------------------------------------------------------------
package mh2_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int unsigned MIX_SHIFT   = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;
  localparam logic [31:0] SEED_RESET  = 32'd97;
  localparam logic [2:0]  FULL_BYTES  = 3'd4;

  // Operations that the datapath carries out.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_K1,
    OP_K2,
    OP_HMIX,
    OP_TAIL,
    OP_FIN,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
  } mh2_cmd_t;

  typedef struct packed {
    logic in_full;
    logic in_tail;
    logic in_last;
    logic last;
    logic out_free;
  } mh2_status_t;

  // Keeps the valid bytes of a word; a count of four or more keeps all.
  function automatic logic [31:0] byte_mask(input logic [2:0] count);
    logic [31:0] mask;
    case (count)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
    return mask;
  endfunction

endpackage

FILE: src/mh2_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MurmurHash2 channel interfaces
// Valid/ready channels for key words, hash results and the seed register.
// ----------------------------------------------------------------------------
interface mh2_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        first_word;
  logic        last_word;
  logic [30:0] key_length;

  modport source (output valid, data_word, byte_count, first_word, last_word, key_length,
                  input ready);
  modport sink (input valid, data_word, byte_count, first_word, last_word, key_length,
                output ready);
endinterface

interface mh2_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

interface mh2_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_seed;

  modport source (output valid, hash_seed, input ready);
  modport sink (input valid, hash_seed, output ready);
endinterface

FILE: src/mh2_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MurmurHash2 datapath
// Seed and running hash registers around one shared constant multiplier.
// ----------------------------------------------------------------------------
module mh2_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  mh2_in_if.sink               in_ch,
  mh2_out_if.source            out_ch,
  mh2_cfg_if.sink              cfg_ch,
  input  mh2_pkg::mh2_cmd_t    cmd,
  output mh2_pkg::mh2_status_t status
);

  logic [31:0] seed_r;
  logic [31:0] h_r;
  logic [31:0] word_r;
  logic [31:0] k_r;
  logic [31:0] out_data_r;
  logic        out_valid_r;
  logic        last_r;
  logic [31:0] mul_a;
  logic [31:0] mul_p;

  // One multiplier by the mixing constant serves every multiply step.
  always_comb begin
    case (cmd.op)
      mh2_pkg::OP_K1:   mul_a = word_r;
      mh2_pkg::OP_K2:   mul_a = k_r ^ (k_r >> mh2_pkg::MIX_SHIFT);
      mh2_pkg::OP_TAIL: mul_a = h_r ^ word_r;
      mh2_pkg::OP_FIN:  mul_a = h_r ^ (h_r >> mh2_pkg::FIN_SHIFT_A);
      default:          mul_a = h_r;
    endcase
  end

  assign mul_p = mul_a * mh2_pkg::MIX_MUL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= mh2_pkg::SEED_RESET;
      h_r         <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        seed_r <= cfg_ch.hash_seed;
      end
      if (cmd.load) begin
        last_r <= in_ch.last_word;
        if (in_ch.first_word) begin
          h_r <= seed_r ^ {1'b0, in_ch.key_length};
        end
      end
      if (cmd.op == mh2_pkg::OP_HMIX) begin
        h_r <= mul_p ^ k_r;
      end else if (cmd.op == mh2_pkg::OP_TAIL) begin
        h_r <= mul_p;
      end
      if (cmd.op == mh2_pkg::OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_r <= in_ch.data_word & mh2_pkg::byte_mask(in_ch.byte_count);
    end
    if (cmd.op == mh2_pkg::OP_K1 || cmd.op == mh2_pkg::OP_K2 ||
        cmd.op == mh2_pkg::OP_FIN) begin
      k_r <= mul_p;
    end
    if (cmd.op == mh2_pkg::OP_OUT) begin
      out_data_r <= k_r ^ (k_r >> mh2_pkg::FIN_SHIFT_B);
    end
  end

  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.hash_value  = out_data_r;

  assign status.in_full  = (in_ch.byte_count >= mh2_pkg::FULL_BYTES);
  assign status.in_tail  = (in_ch.byte_count != 3'd0) &&
                           (in_ch.byte_count < mh2_pkg::FULL_BYTES);
  assign status.in_last  = in_ch.last_word;
  assign status.last     = last_r;
  assign status.out_free = !out_valid_r || out_ch.ready;

  // A new result is only loaded when the previous one has left or is leaving.
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == mh2_pkg::OP_OUT |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten while a result was pending");

endmodule

FILE: src/mh2_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MurmurHash2 controller
// Sequences the mixing, tail and finalization steps of each key word.
// ----------------------------------------------------------------------------
module mh2_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mh2_pkg::mh2_status_t status,
  output mh2_pkg::mh2_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_K1,
    S_K2,
    S_HMIX,
    S_TAIL,
    S_FIN,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.op    = mh2_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.in_full) begin
            state_nxt = S_K1;
          end else if (status.in_tail) begin
            state_nxt = S_TAIL;
          end else if (status.in_last) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_K1: begin
        cmd.op    = mh2_pkg::OP_K1;
        state_nxt = S_K2;
      end
      S_K2: begin
        cmd.op    = mh2_pkg::OP_K2;
        state_nxt = S_HMIX;
      end
      S_HMIX: begin
        cmd.op    = mh2_pkg::OP_HMIX;
        state_nxt = status.last ? S_FIN : S_IDLE;
      end
      S_TAIL: begin
        cmd.op    = mh2_pkg::OP_TAIL;
        state_nxt = status.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        cmd.op    = mh2_pkg::OP_FIN;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.op    = mh2_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // A full word runs through both key multiplies before the hash update.
  a_full_word_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && status.in_full |=> ##1 state_r == S_K2 ##1 state_r == S_HMIX)
    else $error("full word did not follow the mixing sequence");

  // An empty last word goes straight to finalization.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !status.in_full && !status.in_tail && status.in_last
    |=> state_r == S_FIN)
    else $error("empty last word skipped finalization");

  // A tail on the last word is finalized right after it is folded in.
  a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && status.in_tail && status.in_last
    |=> state_r == S_TAIL ##1 state_r == S_FIN)
    else $error("tail on last word not followed by finalization");

  // The controller holds its result step while the output is blocked.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && !status.out_free |=> state_r == S_OUT)
    else $error("controller left the output step while the output was blocked");

endmodule

FILE: src/murmur2_hash_32.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MurmurHash2 32-bit hash engine
// Hashes a key streamed as little-endian 32-bit words and returns one
// finalized 32-bit hash on the last word of each key.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Transfer carries
// in_ch     sink       data_word, byte_count, first_word, last_word, key_length
// out_ch    source     hash_value
// cfg_ch    sink       hash_seed (seed register, reset value 97)
//
// A word of four bytes runs through the transfer, two key multiplies and the
// hash update, a tail word through the transfer and the tail fold, and an
// empty word through its transfer only; a last word adds finalization and
// the result load. Every multiply step shares the single 32-bit constant
// multiplier.
// Reset is synchronous and active low; it clears the running hash to zero
// and the seed to 97. A result waits in the output register until it is
// taken; the next word is accepted meanwhile, and only the following result
// load stalls while that register is still full.
//
// The controller steps through the mixing, tail and finalization phases and
// drives one datapath operation per cycle unless idle or held by a blocked
// output. The datapath keeps the seed, the running hash, the latched (masked)
// word and the intermediate key value, and routes the right operand into the
// multiplier for each operation. The seed register takes a write in any
// cycle; it is only meant to change while no key is in flight.
module murmur2_hash_32 (
  input  logic      clk,
  input  logic      rst_n,
  mh2_in_if.sink    in_ch,
  mh2_out_if.source out_ch,
  mh2_cfg_if.sink   cfg_ch
);

  mh2_pkg::mh2_cmd_t    cmd;
  mh2_pkg::mh2_status_t status;
  logic                 in_ready;

  mh2_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mh2_datapath u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .status (status)
  );

  // Words are taken only between keys' steps, when the controller is idle.
  assign in_ch.ready = in_ready;

endmodule
